// File: hdl/gfcc_pkg.sv
package gfcc_pkg;

   localparam int MAP_SIDE_DEF  = 256;
   localparam int MAX_REACH_DEF = 15;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIM_W      = 9;
   localparam int COORD_W    = 32;
   localparam int LEN_W      = 31;
   localparam int ADDR_IN_W  = 16;
   localparam int OCC_W      = 8;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic signed [OCC_W-1:0] OCC_LIMIT   = 8'sd50;
   localparam logic signed [OCC_W-1:0] OCC_UNKNOWN = -8'sd1;

   typedef enum logic [1:0] {
      VERDICT_FREE    = 2'd0,
      VERDICT_NO_MAP  = 2'd1,
      VERDICT_OUT     = 2'd2,
      VERDICT_BLOCKED = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      JOB_LOAD = 2'd0,
      JOB_DONE = 2'd1,
      JOB_WALK = 2'd2
   } job_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH     = 3'd0,
      CSR_MAP_HEIGHT    = 3'd1,
      CSR_ORIGIN_X      = 3'd2,
      CSR_ORIGIN_Y      = 3'd3,
      CSR_CELL_SIZE     = 3'd4,
      CSR_BODY_RADIUS   = 3'd5,
      CSR_SAFETY_MARGIN = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        [DIM_W-1:0]   map_width;
      logic        [DIM_W-1:0]   map_height;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic        [LEN_W-1:0]   cell_size;
      logic        [LEN_W-1:0]   body_radius;
      logic        [LEN_W-1:0]   safety_margin;
   } cfg_type;

   // must match the job_type layout in the front and back
   function automatic int job_width(int map_side, int max_reach);
      return 2 + 2 + 1 + $clog2(map_side * map_side) + OCC_W + 2 * $clog2(map_side) + 2
         + $clog2(max_reach + 1) + $clog2(2 * max_reach * max_reach + 1) + 2 * DIM_W;
   endfunction

endpackage

// File: hdl/gfcc_ram.sv
module gfcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hdl/gfcc_fifo.sv
module gfcc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// File: hdl/gfcc_front.sv
module gfcc_front #(
   parameter int MAP_SIDE  = gfcc_pkg::MAP_SIDE_DEF,
   parameter int MAX_REACH = gfcc_pkg::MAX_REACH_DEF,
   localparam int JOB_W = gfcc_pkg::job_width(MAP_SIDE, MAX_REACH)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gfcc_pkg::cfg_type                      cfg,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_kind,
   input  logic        [gfcc_pkg::ADDR_IN_W-1:0]  req_cell_address,
   input  logic signed [gfcc_pkg::OCC_W-1:0]      req_cell_value,
   input  logic signed [gfcc_pkg::COORD_W-1:0]    req_query_x,
   input  logic signed [gfcc_pkg::COORD_W-1:0]    req_query_y,
   output logic                                   job_push,
   output logic        [JOB_W-1:0]                job_data,
   input  logic                                   job_full
);

   import gfcc_pkg::*;

   localparam int ADDR_W  = $clog2(MAP_SIDE * MAP_SIDE);
   localparam int IDX_W   = $clog2(MAP_SIDE);
   localparam int RW      = $clog2(MAX_REACH + 1);
   localparam int D2_W    = $clog2(2 * MAX_REACH * MAX_REACH + 1);
   localparam int DBIT_W  = $clog2(IDX_W);
   localparam int SB_W    = (D2_W > 1) ? $clog2(D2_W) : 1;
   localparam int WRES_W  = DIM_W + LEN_W;
   localparam int DIV_W   = LEN_W + IDX_W + 1;
   localparam int RES2_W  = 2 * LEN_W;
   localparam int TOT_W   = LEN_W + 1;
   localparam int TOT2_W  = 2 * TOT_W;
   localparam int ACC_W   = TOT_W + 1;
   localparam int PP_W    = D2_W + LEN_W;
   localparam int PROD_W  = D2_W + RES2_W + 1;

   typedef struct packed {
      job_op_type         op;
      verdict_type        verdict;
      logic               wen;
      logic [ADDR_W-1:0]  waddr;
      logic [OCC_W-1:0]   wdata;
      logic [IDX_W-1:0]   cx;
      logic [IDX_W-1:0]   cy;
      logic               fx;
      logic               fy;
      logic [RW-1:0]      steps;
      logic [D2_W-1:0]    dmax;
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
   } job_type;

   typedef enum logic [3:0] {
      F_IDLE, F_SUB, F_MULW, F_MULH, F_CHK, F_DIV, F_RES2, F_TOT2,
      F_STEPS, F_SRCH_A, F_SRCH_B, F_SRCH_C, F_PUSH
   } state_type;

   state_type                 state_ff, state_in;
   logic                      loaded_ff, loaded_in;
   logic signed [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [COORD_W:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [TOT_W-1:0]          tot_ff, tot_in;
   logic [LEN_W-1:0]          res_ff, res_in;
   logic [DIM_W-1:0]          w_ff, w_in, h_ff, h_in;
   logic [WRES_W-1:0]         wres_ff, wres_in, hres_ff, hres_in;
   logic [COORD_W-1:0]        remx_ff, remx_in, remy_ff, remy_in;
   logic [IDX_W-1:0]          cx_ff, cx_in, cy_ff, cy_in;
   logic [DBIT_W-1:0]         dbit_ff, dbit_in;
   logic [RES2_W-1:0]         res2_ff, res2_in;
   logic [TOT2_W-1:0]         tot2_ff, tot2_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [RW-1:0]             steps_ff, steps_in;
   logic [D2_W-1:0]           dmax_ff, dmax_in;
   logic [SB_W-1:0]           sbit_ff, sbit_in;
   logic [PP_W-1:0]           plo_ff, plo_in, phi_ff, phi_in;
   verdict_type               verdict_ff, verdict_in;
   logic                      walk_ff, walk_in;

   logic                      accept;
   logic [DIV_W-1:0]          trial;
   logic [D2_W-1:0]           cand;
   logic [PROD_W-1:0]         prod;
   job_type                   job;

   assign req_full = (state_ff != F_IDLE) || job_full;
   assign accept   = req_push && !req_full;
   assign trial    = DIV_W'(res_ff) << dbit_ff;
   assign cand     = dmax_ff | (D2_W'(1) << sbit_ff);
   assign prod     = (PROD_W'(phi_ff) << LEN_W) + PROD_W'(plo_ff);
   assign job_data = job;

   always_comb begin
      state_in   = state_ff;
      loaded_in  = loaded_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      tot_in     = tot_ff;
      res_in     = res_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      wres_in    = wres_ff;
      hres_in    = hres_ff;
      remx_in    = remx_ff;
      remy_in    = remy_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      dbit_in    = dbit_ff;
      res2_in    = res2_ff;
      tot2_in    = tot2_ff;
      acc_in     = acc_ff;
      steps_in   = steps_ff;
      dmax_in    = dmax_ff;
      sbit_in    = sbit_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;
      verdict_in = verdict_ff;
      walk_in    = walk_ff;
      job_push   = 1'b0;
      job        = '0;
      job.op     = JOB_DONE;
      job.verdict = VERDICT_NO_MAP;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  job_push  = 1'b1;
                  job.op    = JOB_LOAD;
                  job.wen   = 32'(req_cell_address) < 32'(MAP_SIDE * MAP_SIDE);
                  job.waddr = ADDR_W'(req_cell_address);
                  job.wdata = req_cell_value;
                  loaded_in = 1'b1;
               end else if (!loaded_ff) begin
                  job_push = 1'b1;
               end else begin
                  qx_in    = req_query_x;
                  qy_in    = req_query_y;
                  state_in = F_SUB;
               end
            end
         end
         F_SUB: begin
            rx_in  = (COORD_W+1)'(qx_ff) - (COORD_W+1)'(cfg.origin_x);
            ry_in  = (COORD_W+1)'(qy_ff) - (COORD_W+1)'(cfg.origin_y);
            tot_in = TOT_W'(cfg.body_radius) + TOT_W'(cfg.safety_margin);
            res_in = (cfg.cell_size == '0) ? LEN_W'(1) : cfg.cell_size;
            w_in   = (32'(cfg.map_width) > 32'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : cfg.map_width;
            h_in   = (32'(cfg.map_height) > 32'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : cfg.map_height;
            state_in = F_MULW;
         end
         F_MULW: begin
            wres_in  = WRES_W'(w_ff) * WRES_W'(res_ff);
            state_in = F_MULH;
         end
         F_MULH: begin
            hres_in  = WRES_W'(h_ff) * WRES_W'(res_ff);
            state_in = F_CHK;
         end
         F_CHK: begin
            if (w_ff == '0 || h_ff == '0 || rx_ff[COORD_W] || ry_ff[COORD_W]
                || WRES_W'(rx_ff[COORD_W-1:0]) >= wres_ff
                || WRES_W'(ry_ff[COORD_W-1:0]) >= hres_ff) begin
               verdict_in = VERDICT_OUT;
               walk_in    = 1'b0;
               state_in   = F_PUSH;
            end else begin
               remx_in  = rx_ff[COORD_W-1:0];
               remy_in  = ry_ff[COORD_W-1:0];
               cx_in    = '0;
               cy_in    = '0;
               dbit_in  = DBIT_W'(IDX_W - 1);
               walk_in  = 1'b1;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (DIV_W'(remx_ff) >= trial) begin
               remx_in        = COORD_W'(DIV_W'(remx_ff) - trial);
               cx_in[dbit_ff] = 1'b1;
            end
            if (DIV_W'(remy_ff) >= trial) begin
               remy_in        = COORD_W'(DIV_W'(remy_ff) - trial);
               cy_in[dbit_ff] = 1'b1;
            end
            dbit_in = dbit_ff - 1'b1;
            if (dbit_ff == '0) begin
               state_in = F_RES2;
            end
         end
         F_RES2: begin
            res2_in  = RES2_W'(res_ff) * RES2_W'(res_ff);
            state_in = F_TOT2;
         end
         F_TOT2: begin
            tot2_in  = TOT2_W'(tot_ff) * TOT2_W'(tot_ff);
            acc_in   = '0;
            steps_in = '0;
            state_in = F_STEPS;
         end
         F_STEPS: begin
            // ceil(total / res), capped at the reach
            if (steps_ff < RW'(MAX_REACH) && acc_ff < ACC_W'(tot_ff)) begin
               acc_in   = acc_ff + ACC_W'(res_ff);
               steps_in = steps_ff + 1'b1;
            end else begin
               dmax_in  = '0;
               sbit_in  = SB_W'(D2_W - 1);
               state_in = F_SRCH_A;
            end
         end
         F_SRCH_A: begin
            plo_in   = PP_W'(cand) * PP_W'(res2_ff[LEN_W-1:0]);
            state_in = F_SRCH_B;
         end
         F_SRCH_B: begin
            phi_in   = PP_W'(cand) * PP_W'(res2_ff[RES2_W-1:LEN_W]);
            state_in = F_SRCH_C;
         end
         F_SRCH_C: begin
            // largest squared offset that stays inside the radius
            if (prod <= PROD_W'(tot2_ff)) begin
               dmax_in = cand;
            end
            sbit_in = sbit_ff - 1'b1;
            state_in = (sbit_ff == '0) ? F_PUSH : F_SRCH_A;
         end
         F_PUSH: begin
            job.op      = walk_ff ? JOB_WALK : JOB_DONE;
            job.verdict = verdict_ff;
            job.cx      = cx_ff;
            job.cy      = cy_ff;
            job.fx      = (remx_ff != '0);
            job.fy      = (remy_ff != '0);
            job.steps   = steps_ff;
            job.dmax    = dmax_ff;
            job.w       = w_ff;
            job.h       = h_ff;
            if (!job_full) begin
               job_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         loaded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      tot_ff     <= tot_in;
      res_ff     <= res_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      wres_ff    <= wres_in;
      hres_ff    <= hres_in;
      remx_ff    <= remx_in;
      remy_ff    <= remy_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      dbit_ff    <= dbit_in;
      res2_ff    <= res2_in;
      tot2_ff    <= tot2_in;
      acc_ff     <= acc_in;
      steps_ff   <= steps_in;
      dmax_ff    <= dmax_in;
      sbit_ff    <= sbit_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      verdict_ff <= verdict_in;
      walk_ff    <= walk_in;
   end

endmodule

// File: hdl/gfcc_back.sv
module gfcc_back #(
   parameter int MAP_SIDE  = gfcc_pkg::MAP_SIDE_DEF,
   parameter int MAX_REACH = gfcc_pkg::MAX_REACH_DEF,
   localparam int JOB_W = gfcc_pkg::job_width(MAP_SIDE, MAX_REACH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   input  logic [JOB_W-1:0]      job_data,
   output logic                  job_pop,
   output logic                  rsp_push,
   output gfcc_pkg::verdict_type rsp_data,
   input  logic                  rsp_full
);

   import gfcc_pkg::*;

   localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
   localparam int IDX_W  = $clog2(MAP_SIDE);
   localparam int RW     = $clog2(MAX_REACH + 1);
   localparam int D2_W   = $clog2(2 * MAX_REACH * MAX_REACH + 1);
   localparam int OFF_W  = RW + 1;
   localparam int TX_W   = ((IDX_W > RW) ? IDX_W : RW) + 2;
   localparam int CMP_W  = (TX_W > DIM_W + 1) ? TX_W : DIM_W + 1;
   localparam int SQ_W   = D2_W + 1;
   localparam int MUL_W  = IDX_W + DIM_W + 1;

   typedef struct packed {
      job_op_type         op;
      verdict_type        verdict;
      logic               wen;
      logic [ADDR_W-1:0]  waddr;
      logic [OCC_W-1:0]   wdata;
      logic [IDX_W-1:0]   cx;
      logic [IDX_W-1:0]   cy;
      logic               fx;
      logic               fy;
      logic [RW-1:0]      steps;
      logic [D2_W-1:0]    dmax;
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
   } job_type;

   typedef enum logic [2:0] {
      B_IDLE, B_WALK, B_DRAIN1, B_DRAIN2, B_RESULT
   } state_type;

   state_type               state_ff, state_in;
   job_type                 job, cur_ff, cur_in;
   logic signed [OFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [OFF_W-1:0] top;
   logic                    s1_v_ff, s1_v_in, s2_v_ff;
   logic [IDX_W-1:0]        s1_mx_ff, s1_mx_in, s1_my_ff, s1_my_in;
   verdict_type             verdict_ff, verdict_in;

   logic [RW-1:0]           adx, ady;
   logic [SQ_W-1:0]         sum2;
   logic signed [TX_W-1:0]  tx, ty;
   logic                    mx_ok, my_ok, keep;
   logic [MUL_W-1:0]        lin;
   logic                    ram_we;
   logic [ADDR_W-1:0]       raddr;
   logic signed [OCC_W-1:0] rdata;
   logic                    blk;

   assign job  = job_data;
   assign top  = OFF_W'(cur_ff.steps);
   assign adx  = dx_ff[OFF_W-1] ? RW'(-dx_ff) : RW'(dx_ff);
   assign ady  = dy_ff[OFF_W-1] ? RW'(-dy_ff) : RW'(dy_ff);
   assign sum2 = SQ_W'(adx) * SQ_W'(adx) + SQ_W'(ady) * SQ_W'(ady);
   assign keep = sum2 <= SQ_W'(cur_ff.dmax);
   assign tx   = $signed(TX_W'(cur_ff.cx)) + TX_W'(dx_ff);
   assign ty   = $signed(TX_W'(cur_ff.cy)) + TX_W'(dy_ff);

   // an index one below zero truncates to zero when the point is off the cell edge
   assign mx_ok = (!tx[TX_W-1] && CMP_W'(tx) < CMP_W'(cur_ff.w)) || (tx == '1 && cur_ff.fx);
   assign my_ok = (!ty[TX_W-1] && CMP_W'(ty) < CMP_W'(cur_ff.h)) || (ty == '1 && cur_ff.fy);

   assign lin   = MUL_W'(s1_my_ff) * MUL_W'(cur_ff.w) + MUL_W'(s1_mx_ff);
   assign raddr = ADDR_W'(lin);
   assign blk   = s2_v_ff && (rdata > OCC_LIMIT || rdata == OCC_UNKNOWN);

   gfcc_ram #(
      .WIDTH(OCC_W),
      .DEPTH(MAP_SIDE * MAP_SIDE)
   ) u_grid (
      .clock(clock),
      .we(ram_we),
      .waddr(job.waddr),
      .wdata(job.wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      verdict_in = verdict_ff;
      job_pop    = 1'b0;
      ram_we     = 1'b0;
      rsp_push   = 1'b0;
      rsp_data   = verdict_ff;
      s1_v_in    = 1'b0;
      s1_mx_in   = tx[TX_W-1] ? '0 : IDX_W'(tx);
      s1_my_in   = ty[TX_W-1] ? '0 : IDX_W'(ty);

      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               unique case (job.op)
                  JOB_LOAD: ram_we = job.wen;
                  JOB_DONE: begin
                     verdict_in = job.verdict;
                     state_in   = B_RESULT;
                  end
                  JOB_WALK: begin
                     cur_in     = job;
                     dx_in      = -OFF_W'(job.steps);
                     dy_in      = -OFF_W'(job.steps);
                     verdict_in = VERDICT_FREE;
                     state_in   = B_WALK;
                  end
                  default: ;
               endcase
            end
         end
         B_WALK: begin
            s1_v_in = keep && mx_ok && my_ok;
            if (dy_ff == top) begin
               dy_in = -top;
               if (dx_ff == top) begin
                  state_in = B_DRAIN1;
               end else begin
                  dx_in = dx_ff + 1'b1;
               end
            end else begin
               dy_in = dy_ff + 1'b1;
            end
         end
         B_DRAIN1: state_in = B_DRAIN2;
         B_DRAIN2: state_in = B_RESULT;
         B_RESULT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase

      if (blk) begin
         verdict_in = VERDICT_BLOCKED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      s1_mx_ff   <= s1_mx_in;
      s1_my_ff   <= s1_my_in;
      verdict_ff <= verdict_in;
   end

endmodule

// File: hdl/grid_footprint_collision_check.sv
// Occupancy grid footprint collision check.
// Request channel (req_push / req_full): a load request writes one grid cell,
// a query request asks whether a circular footprint at a point is clear.
// Result channel (rsp_empty / rsp_pop): one result per query, none per load,
// in request order; the oldest result sits on rsp_* while rsp_empty is low.
// CSR channel (csr_valid / csr_ready, always ready): register writes, which the
// user must make only while no request is in flight; the block does not enforce it.
// Loads are taken at one per cycle while the front is idle and the job queue is
// not full. A query passes through the front (bound check, cell divide, reach
// count, radius search with a split 62-bit multiply), then the back walks
// (2*steps+1)^2 offsets with the one-read-per-cycle grid memory; steps is at
// most MAX_REACH. The front works on the next request while the back walks,
// through a four-entry job queue. Reset clears the map-loaded flag, the queues
// and the CSR registers to their defaults; grid contents are kept and undefined
// until loaded. When rsp_pop is held low the result queue fills, the back
// stalls, then the job queue fills and req_full rises.
module grid_footprint_collision_check #(
   parameter int MAP_SIDE  = gfcc_pkg::MAP_SIDE_DEF,
   parameter int MAX_REACH = gfcc_pkg::MAX_REACH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_kind,
   input  logic        [gfcc_pkg::ADDR_IN_W-1:0]  req_cell_address,
   input  logic signed [gfcc_pkg::OCC_W-1:0]      req_cell_value,
   input  logic signed [gfcc_pkg::COORD_W-1:0]    req_query_x,
   input  logic signed [gfcc_pkg::COORD_W-1:0]    req_query_y,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic                                   rsp_point_free,
   output logic        [1:0]                      rsp_verdict,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [gfcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [gfcc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import gfcc_pkg::*;

   localparam int JOB_W = job_width(MAP_SIDE, MAX_REACH);

   cfg_type           cfg_ff;
   logic              job_push, job_full, job_empty, job_pop;
   logic [JOB_W-1:0]  job_wdata, job_rdata;
   logic              res_push, res_full;
   verdict_type       res_data;
   logic [1:0]        res_head;

   assign csr_ready      = 1'b1;
   assign rsp_verdict    = res_head;
   assign rsp_point_free = (res_head == VERDICT_FREE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width     <= DIM_W'(256);
         cfg_ff.map_height    <= DIM_W'(256);
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.cell_size     <= LEN_W'(3277);
         cfg_ff.body_radius   <= LEN_W'(19661);
         cfg_ff.safety_margin <= LEN_W'(6554);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:     cfg_ff.map_width     <= csr_wdata[DIM_W-1:0];
            CSR_MAP_HEIGHT:    cfg_ff.map_height    <= csr_wdata[DIM_W-1:0];
            CSR_ORIGIN_X:      cfg_ff.origin_x      <= csr_wdata;
            CSR_ORIGIN_Y:      cfg_ff.origin_y      <= csr_wdata;
            CSR_CELL_SIZE:     cfg_ff.cell_size     <= csr_wdata[LEN_W-1:0];
            CSR_BODY_RADIUS:   cfg_ff.body_radius   <= csr_wdata[LEN_W-1:0];
            CSR_SAFETY_MARGIN: cfg_ff.safety_margin <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   gfcc_front #(
      .MAP_SIDE(MAP_SIDE),
      .MAX_REACH(MAX_REACH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_push(req_push),
      .req_full(req_full),
      .req_kind(req_kind),
      .req_cell_address(req_cell_address),
      .req_cell_value(req_cell_value),
      .req_query_x(req_query_x),
      .req_query_y(req_query_y),
      .job_push(job_push),
      .job_data(job_wdata),
      .job_full(job_full)
   );

   gfcc_fifo #(
      .WIDTH(JOB_W),
      .DEPTH(4)
   ) u_job_q (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .wdata(job_wdata),
      .full(job_full),
      .pop(job_pop),
      .rdata(job_rdata),
      .empty(job_empty)
   );

   gfcc_back #(
      .MAP_SIDE(MAP_SIDE),
      .MAX_REACH(MAX_REACH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_empty(job_empty),
      .job_data(job_rdata),
      .job_pop(job_pop),
      .rsp_push(res_push),
      .rsp_data(res_data),
      .rsp_full(res_full)
   );

   gfcc_fifo #(
      .WIDTH(2),
      .DEPTH(2)
   ) u_rsp_q (
      .clock(clock),
      .reset(reset),
      .push(res_push),
      .wdata(res_data),
      .full(res_full),
      .pop(rsp_pop),
      .rdata(res_head),
      .empty(rsp_empty)
   );

endmodule

// File: hdl/gfcc_checker.sv
module gfcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_point_free,
   input logic [1:0] rsp_verdict
);

   import gfcc_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   a_free_match: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_point_free == (rsp_verdict == VERDICT_FREE)))
      else $error("point_free disagrees with verdict");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_verdict))
      else $error("stalled result changed");

endmodule

bind grid_footprint_collision_check gfcc_checker u_checker (.*);
